/* hw/rtl/art_pkg.sv */
// ----------------------------------------------------------------------------
// ART package
// Shared constants, codes and types of the acknowledgement retransmit tracker.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [31:0] frame;
    logic [15:0] fragment;
    logic [31:0] first_send;
    logic [31:0] last_send;
    logic [3:0]  retries;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Input transaction kinds.
  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Result kinds.
  typedef enum logic [2:0] {
    RES_RETX      = 3'd0,
    RES_INSERTED  = 3'd1,
    RES_DUPLICATE = 3'd2,
    RES_FULL      = 3'd3,
    RES_ACK_HIT   = 3'd4,
    RES_ACK_MISS  = 3'd5,
    RES_NO_TMO    = 3'd6,
    RES_KEY_FORCE = 3'd7
  } res_kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd0;
  localparam logic [1:0] CFG_EWMA_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_GIVE_UP     = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EWMA,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DISPATCH,
    ST_INS_RD,
    ST_INS_WR,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_REM_RD,
    ST_REM_WR,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] out_frame_number;
    logic [15:0] out_fragment_number;
    logic [3:0]  retry_count;
    logic [31:0] min_rtt_us;
    logic [31:0] smoothed_rtt_us;
    logic        last;
  } result_t;

  // Strict key order: (fa, ga) < (fb, gb).
  function automatic logic key_less(input logic [31:0] fa, input logic [15:0] ga,
                                    input logic [31:0] fb, input logic [15:0] gb);
    key_less = (fa < fb) || ((fa == fb) && (ga < gb));
  endfunction

endpackage

/* hw/rtl/art_if.sv */
// ----------------------------------------------------------------------------
// ART channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
interface art_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] frame_number;
  logic [15:0] fragment_number;
  logic [31:0] now_us;
  logic [31:0] stamp_us;
  modport source (output valid, kind, frame_number, fragment_number, now_us, stamp_us,
                  input ready);
  modport sink   (input valid, kind, frame_number, fragment_number, now_us, stamp_us,
                  output ready);
endinterface

interface art_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [31:0] out_frame_number;
  logic [15:0] out_fragment_number;
  logic [3:0]  retry_count;
  logic [31:0] min_rtt_us;
  logic [31:0] smoothed_rtt_us;
  logic        last;
  modport source (output valid, result_kind, out_frame_number, out_fragment_number,
                  retry_count, min_rtt_us, smoothed_rtt_us, last, input ready);
  modport sink   (input valid, result_kind, out_frame_number, out_fragment_number,
                  retry_count, min_rtt_us, smoothed_rtt_us, last, output ready);
endinterface

interface art_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/art_ram.sv */
// ----------------------------------------------------------------------------
// ART generic RAM
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read of the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/art_ewma.sv */
// ----------------------------------------------------------------------------
// ART RTT estimator
// Holds the minimum and smoothed RTT and folds in one sample per request.
// ----------------------------------------------------------------------------
module art_ewma (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        sample_vld,
  input  logic [31:0] sample,
  input  logic [8:0]  weight,
  output logic [31:0] min_rtt,
  output logic [31:0] smoothed_rtt
);

  logic [31:0] min_r, min_nxt;
  logic [31:0] srtt_r, srtt_nxt;
  logic        seen_r;
  logic [8:0]  w;
  logic [8:0]  wc;
  logic [41:0] acc;

  // Saturate the weight and form the rounded weighted sum.
  always_comb begin
    w   = (weight > 9'd256) ? 9'd256 : weight;
    wc  = 9'd256 - w;
    acc = 42'(w) * 42'(sample) + 42'(wc) * 42'(srtt_r) + 42'd128;
    min_nxt  = min_r;
    srtt_nxt = srtt_r;
    if (sample_vld) begin
      if (!seen_r || sample < min_r) begin
        min_nxt = sample;
      end
      srtt_nxt = seen_r ? acc[39:8] : sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= '0;
      srtt_r <= '0;
      seen_r <= 1'b0;
    end else begin
      min_r  <= min_nxt;
      srtt_r <= srtt_nxt;
      if (sample_vld) begin
        seen_r <= 1'b1;
      end
    end
  end

  assign min_rtt      = min_r;
  assign smoothed_rtt = srtt_r;

endmodule

/* hw/rtl/ack_retransmit_tracker_top.sv */
// ----------------------------------------------------------------------------
// Acknowledgement retransmit tracker
// Sorted table of unacknowledged fragments with selective retransmission.
// ----------------------------------------------------------------------------
// One transaction at a time over the single-port entry memory; a new input is
// taken only when idle. Sends and acks scan the table entry by entry, a frame
// check reads only the first entry; results may wait for the output register.
// Reset (synchronous, rst_n low) empties the table, clears the RTT state and
// loads the register defaults; the entry memory itself is not cleared.
module ack_retransmit_tracker_top (
  input logic       clk,
  input logic       rst_n,
  art_in_if.sink    in_ch,
  art_out_if.source out_ch,
  art_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic [3:0]  max_retries_r;
  logic [8:0]  weight_r;
  logic [31:0] give_up_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= 4'd3;
      weight_r      <= 9'd51;
      give_up_r     <= 32'd1000000;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        art_pkg::CFG_MAX_RETRIES: max_retries_r <= cfg_ch.data[3:0];
        art_pkg::CFG_EWMA_WEIGHT: weight_r      <= cfg_ch.data[8:0];
        art_pkg::CFG_GIVE_UP:     give_up_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  art_pkg::state_t state_r, state_nxt;
  logic [1:0]  kind_r;
  logic [31:0] fr_r, now_r, stamp_r;
  logic [15:0] fg_r;
  logic [art_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [art_pkg::CNT_W-1:0] ptr_r, ptr_nxt;
  logic [art_pkg::CNT_W-1:0] pos_r, pos_nxt;
  logic [art_pkg::RES_CNT_W:0] nres_r, nres_nxt;
  logic        hit_r, hit_nxt;
  logic        walk_r, walk_nxt;
  art_pkg::entry_t carry_r, carry_nxt;
  logic [3:0]  ack_rc_r, ack_rc_nxt;

  // Output register, and the final status result built while it is busy.
  logic            ovld_r, ovld_nxt;
  art_pkg::result_t ores_r, ores_nxt;
  art_pkg::result_t fin_r, fin_nxt;

  // Memory port.
  logic                      mem_we;
  logic [art_pkg::IDX_W-1:0] mem_addr;
  art_pkg::entry_t           mem_wdata, rd;
  logic [art_pkg::ENTRY_W-1:0] mem_rdata;

  art_ram #(.WIDTH(art_pkg::ENTRY_W), .DEPTH(art_pkg::TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );
  assign rd = art_pkg::entry_t'(mem_rdata);

  // RTT estimator.
  logic        samp_vld;
  logic [31:0] min_rtt, srtt;

  art_ewma u_ewma (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_vld   (samp_vld),
    .sample       (now_r - stamp_r),
    .weight       (weight_r),
    .min_rtt      (min_rtt),
    .smoothed_rtt (srtt)
  );

  assign in_ch.ready = (state_r == art_pkg::ST_IDLE);

  logic [art_pkg::IDX_W-1:0] ptr_idx;
  assign ptr_idx = ptr_r[art_pkg::IDX_W-1:0];

  // Next state, memory control and result formation.
  always_comb begin
    art_pkg::entry_t e;
    logic            ovl_free;
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    pos_nxt    = pos_r;
    nres_nxt   = nres_r;
    hit_nxt    = hit_r;
    walk_nxt   = walk_r;
    carry_nxt  = carry_r;
    ack_rc_nxt = ack_rc_r;
    ovld_nxt   = ovld_r;
    ores_nxt   = ores_r;
    fin_nxt    = fin_r;
    mem_we     = 1'b0;
    mem_addr   = ptr_idx;
    mem_wdata  = rd;
    samp_vld   = 1'b0;
    e          = rd;
    ovl_free   = !ovld_r || out_ch.ready;
    if (ovld_r && out_ch.ready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      art_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          ptr_nxt  = '0;
          nres_nxt = '0;
          hit_nxt  = 1'b0;
          unique case (art_pkg::kind_t'(in_ch.kind))
            art_pkg::KIND_SEND:  state_nxt = (count_r == '0) ? art_pkg::ST_DISPATCH
                                                              : art_pkg::ST_SRCH_RD;
            art_pkg::KIND_ACK:   state_nxt = art_pkg::ST_EWMA;
            art_pkg::KIND_CHECK: state_nxt = art_pkg::ST_CHK_RD;
            default:             state_nxt = art_pkg::ST_IDLE;
          endcase
        end
      end

      art_pkg::ST_EWMA: begin
        samp_vld  = 1'b1;
        state_nxt = (count_r == '0) ? art_pkg::ST_DISPATCH : art_pkg::ST_SRCH_RD;
      end

      // Lower bound: linear scan, each read followed by a compare state.
      art_pkg::ST_SRCH_RD: begin
        state_nxt = art_pkg::ST_SRCH_CMP;
      end

      art_pkg::ST_SRCH_CMP: begin
        if (art_pkg::key_less(rd.frame, rd.fragment, fr_r, fg_r)) begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = (ptr_r + 1'b1 == count_r) ? art_pkg::ST_DISPATCH
                                                : art_pkg::ST_SRCH_RD;
        end else begin
          hit_nxt   = (rd.frame == fr_r) && (rd.fragment == fg_r);
          state_nxt = art_pkg::ST_DISPATCH;
        end
      end

      // Decide the action once the position is known.
      art_pkg::ST_DISPATCH: begin
        pos_nxt = ptr_r;
        if (kind_r == art_pkg::KIND_SEND) begin
          if (hit_r || count_r == art_pkg::CNT_W'(art_pkg::TABLE_DEPTH)) begin
            fin_nxt.result_kind = hit_r ? art_pkg::RES_DUPLICATE : art_pkg::RES_FULL;
            fin_nxt.retry_count = '0;
            state_nxt = art_pkg::ST_EMIT;
          end else begin
            // Shift entries up from the position, carrying one entry along.
            carry_nxt = '{frame: fr_r, fragment: fg_r, first_send: stamp_r,
                          last_send: stamp_r, retries: 4'd0};
            state_nxt = (ptr_r == count_r) ? art_pkg::ST_INS_WR : art_pkg::ST_INS_RD;
          end
        end else begin
          if (!hit_r) begin
            fin_nxt.result_kind = art_pkg::RES_ACK_MISS;
            fin_nxt.retry_count = '0;
            state_nxt = art_pkg::ST_EMIT;
          end else begin
            walk_nxt  = 1'b1;
            ptr_nxt   = ptr_r;
            state_nxt = (ptr_r == '0) ? art_pkg::ST_REM_RD : art_pkg::ST_WALK_RD;
            if (ptr_r != '0) begin
              ptr_nxt = ptr_r - 1'b1;
            end
          end
        end
      end

      art_pkg::ST_INS_RD: begin
        state_nxt = art_pkg::ST_INS_WR;
      end

      art_pkg::ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = carry_r;
        if (ptr_r == count_r) begin
          count_nxt = count_r + 1'b1;
          fin_nxt.result_kind = art_pkg::RES_INSERTED;
          fin_nxt.retry_count = '0;
          state_nxt = art_pkg::ST_EMIT;
        end else begin
          carry_nxt = rd;
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = (ptr_r + 1'b1 == count_r) ? art_pkg::ST_INS_WR : art_pkg::ST_INS_RD;
        end
      end

      // Descending walk over earlier entries.
      art_pkg::ST_WALK_RD: begin
        state_nxt = art_pkg::ST_WALK_CMP;
      end

      art_pkg::ST_WALK_CMP: begin
        if (ovl_free) begin
          if (rd.retries < max_retries_r &&
              (rd.retries == 4'd0 || (now_r - rd.last_send) > srtt)) begin
            e.retries   = rd.retries + 4'd1;
            e.last_send = now_r;
            mem_we      = 1'b1;
            mem_wdata   = e;
            ovld_nxt    = 1'b1;
            ores_nxt    = '{result_kind: art_pkg::RES_RETX, out_frame_number: rd.frame,
                            out_fragment_number: rd.fragment, retry_count: e.retries,
                            min_rtt_us: min_rtt, smoothed_rtt_us: srtt, last: 1'b0};
            nres_nxt    = nres_r + 1'b1;
          end
          if (ptr_r == '0 ||
              nres_nxt == (art_pkg::RES_CNT_W + 1)'(art_pkg::MAX_RESULTS - 1)) begin
            ptr_nxt   = pos_r;
            state_nxt = art_pkg::ST_REM_RD;
          end else begin
            ptr_nxt   = ptr_r - 1'b1;
            state_nxt = art_pkg::ST_WALK_RD;
          end
        end
      end

      // Removal: read acked entry's retries, then shift entries down.
      art_pkg::ST_REM_RD: begin
        if (ptr_r == pos_r && walk_r) begin
          state_nxt = art_pkg::ST_REM_WR;
        end else begin
          mem_addr  = art_pkg::IDX_W'(ptr_r + 1'b1);
          state_nxt = art_pkg::ST_REM_WR;
        end
      end

      art_pkg::ST_REM_WR: begin
        if (walk_r) begin
          ack_rc_nxt = rd.retries;
          walk_nxt   = 1'b0;
          if (ptr_r + 1'b1 == count_r) begin
            count_nxt = count_r - 1'b1;
            fin_nxt.result_kind = art_pkg::RES_ACK_HIT;
            fin_nxt.retry_count = rd.retries;
            state_nxt = art_pkg::ST_EMIT;
          end else begin
            state_nxt = art_pkg::ST_REM_RD;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = rd;
          if (ptr_r + 2'd2 == count_r) begin
            count_nxt = count_r - 1'b1;
            fin_nxt.result_kind = art_pkg::RES_ACK_HIT;
            fin_nxt.retry_count = ack_rc_r;
            state_nxt = art_pkg::ST_EMIT;
          end else begin
            ptr_nxt   = ptr_r + 1'b1;
            state_nxt = art_pkg::ST_REM_RD;
          end
        end
      end

      // Frame check on the smallest-key entry.
      art_pkg::ST_CHK_RD: begin
        mem_addr  = '0;
        state_nxt = art_pkg::ST_CHK_CMP;
      end

      art_pkg::ST_CHK_CMP: begin
        state_nxt = art_pkg::ST_EMIT;
        if (count_r != '0 && (now_r - rd.first_send) > give_up_r) begin
          count_nxt = '0;
          fin_nxt.result_kind         = art_pkg::RES_KEY_FORCE;
          fin_nxt.retry_count         = rd.retries;
          fin_nxt.out_frame_number    = rd.frame;
          fin_nxt.out_fragment_number = rd.fragment;
        end else begin
          fin_nxt.result_kind         = art_pkg::RES_NO_TMO;
          fin_nxt.retry_count         = '0;
          fin_nxt.out_frame_number    = '0;
          fin_nxt.out_fragment_number = '0;
        end
      end

      // Final status result of the transaction.
      art_pkg::ST_EMIT: begin
        if (ovl_free) begin
          ovld_nxt = 1'b1;
          ores_nxt = fin_r;
          ores_nxt.min_rtt_us      = min_rtt;
          ores_nxt.smoothed_rtt_us = srtt;
          ores_nxt.last            = 1'b1;
          if (kind_r != art_pkg::KIND_CHECK) begin
            ores_nxt.out_frame_number    = fr_r;
            ores_nxt.out_fragment_number = fg_r;
          end
          state_nxt = art_pkg::ST_IDLE;
        end
      end

      default: state_nxt = art_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= art_pkg::ST_IDLE;
      count_r <= '0;
      ovld_r  <= 1'b0;
      walk_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
      walk_r  <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == art_pkg::ST_IDLE && in_ch.valid) begin
      kind_r  <= in_ch.kind;
      fr_r    <= in_ch.frame_number;
      fg_r    <= in_ch.fragment_number;
      now_r   <= in_ch.now_us;
      stamp_r <= in_ch.stamp_us;
    end
    ptr_r    <= ptr_nxt;
    pos_r    <= pos_nxt;
    nres_r   <= nres_nxt;
    hit_r    <= hit_nxt;
    carry_r  <= carry_nxt;
    ack_rc_r <= ack_rc_nxt;
    ores_r   <= ores_nxt;
    fin_r    <= fin_nxt;
  end

  assign out_ch.valid               = ovld_r;
  assign out_ch.result_kind         = ores_r.result_kind;
  assign out_ch.out_frame_number    = ores_r.out_frame_number;
  assign out_ch.out_fragment_number = ores_r.out_fragment_number;
  assign out_ch.retry_count         = ores_r.retry_count;
  assign out_ch.min_rtt_us          = ores_r.min_rtt_us;
  assign out_ch.smoothed_rtt_us     = ores_r.smoothed_rtt_us;
  assign out_ch.last                = ores_r.last;

endmodule

/* tb/art_scoreboard.sv */
// ----------------------------------------------------------------------------
// Retransmit tracker scoreboard
// Watches the input, configuration and result channels of the tracker. It
// keeps its own copy of the fragment table and RTT state, works out the
// results due for every accepted input transaction, and compares each
// accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module art_scoreboard
  import art_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  art_in_if    in_mon,
  art_out_if   out_mon,
  art_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the fragment table, kept in ascending key order.
  logic [31:0] tbl_frame [TABLE_DEPTH];
  logic [15:0] tbl_frag  [TABLE_DEPTH];
  logic [31:0] tbl_first [TABLE_DEPTH];
  logic [31:0] tbl_last  [TABLE_DEPTH];
  logic [3:0]  tbl_retry [TABLE_DEPTH];
  int          tbl_count;

  // RTT estimate and configuration copy.
  logic [31:0] rtt_min;
  logic [31:0] rtt_avg;
  bit          have_rtt;
  logic [3:0]  cfg_retries;
  logic [8:0]  cfg_weight;
  logic [31:0] cfg_give_up;

  result_t     results_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Builds one result carrying the RTT state as it stands.
  function automatic result_t make_result(res_kind_t k, logic [31:0] fr, logic [15:0] fg,
                                          logic [3:0] rc, logic fin);
    result_t r;
    r.result_kind         = k;
    r.out_frame_number    = fr;
    r.out_fragment_number = fg;
    r.retry_count         = rc;
    r.min_rtt_us          = rtt_min;
    r.smoothed_rtt_us     = rtt_avg;
    r.last                = fin;
    return r;
  endfunction

  // Folds one round-trip sample into the minimum and the average, using a Q8 weight.
  task automatic take_rtt(logic [31:0] s);
    logic [63:0] w;
    logic [63:0] acc;
    if (!have_rtt || s < rtt_min) rtt_min = s;
    if (!have_rtt) begin
      rtt_avg = s;
    end else begin
      w   = (cfg_weight > 9'd256) ? 64'd256 : {55'd0, cfg_weight};
      acc = w * s + (64'd256 - w) * rtt_avg + 64'd128;
      rtt_avg = acc[39:8];
    end
    have_rtt = 1'b1;
  endtask

  // Updates the shadow table for one input transaction and queues its results.
  task automatic track_item(logic [1:0] kind, logic [31:0] fr, logic [15:0] fg,
                            logic [31:0] now, logic [31:0] stamp);
    int          p;
    int          i;
    int          j;
    int          n;
    bit          hit;
    logic [31:0] age;
    logic [3:0]  rc;
    n = 0;
    if (kind == KIND_ACK) take_rtt(now - stamp);
    p = 0;
    while (p < tbl_count &&
           (tbl_frame[p] < fr || (tbl_frame[p] == fr && tbl_frag[p] < fg)))
      p++;
    hit = (p < tbl_count) && (tbl_frame[p] == fr) && (tbl_frag[p] == fg);
    case (kind)
      KIND_SEND: begin
        if (hit) begin
          results_due.push_back(make_result(RES_DUPLICATE, fr, fg, 4'd0, 1'b1));
        end else if (tbl_count >= TABLE_DEPTH) begin
          results_due.push_back(make_result(RES_FULL, fr, fg, 4'd0, 1'b1));
        end else begin
          for (i = tbl_count; i > p; i--) begin
            tbl_frame[i] = tbl_frame[i-1];
            tbl_frag[i]  = tbl_frag[i-1];
            tbl_first[i] = tbl_first[i-1];
            tbl_last[i]  = tbl_last[i-1];
            tbl_retry[i] = tbl_retry[i-1];
          end
          tbl_frame[p] = fr;
          tbl_frag[p]  = fg;
          tbl_first[p] = stamp;
          tbl_last[p]  = stamp;
          tbl_retry[p] = 4'd0;
          tbl_count++;
          results_due.push_back(make_result(RES_INSERTED, fr, fg, 4'd0, 1'b1));
        end
      end
      KIND_ACK: begin
        if (!hit) begin
          results_due.push_back(make_result(RES_ACK_MISS, fr, fg, 4'd0, 1'b1));
        end else begin
          // Walk the smaller keys downwards and resend the ones that qualify.
          for (i = p; i > 0 && n < MAX_RESULTS - 1; i--) begin
            j   = i - 1;
            age = now - tbl_last[j];
            if (tbl_retry[j] < cfg_retries && (tbl_retry[j] == 4'd0 || age > rtt_avg)) begin
              tbl_retry[j] = tbl_retry[j] + 4'd1;
              tbl_last[j]  = now;
              results_due.push_back(make_result(RES_RETX, tbl_frame[j], tbl_frag[j],
                                                tbl_retry[j], 1'b0));
              n++;
            end
          end
          rc = tbl_retry[p];
          for (i = p; i + 1 < tbl_count; i++) begin
            tbl_frame[i] = tbl_frame[i+1];
            tbl_frag[i]  = tbl_frag[i+1];
            tbl_first[i] = tbl_first[i+1];
            tbl_last[i]  = tbl_last[i+1];
            tbl_retry[i] = tbl_retry[i+1];
          end
          tbl_count--;
          results_due.push_back(make_result(RES_ACK_HIT, fr, fg, rc, 1'b1));
        end
      end
      KIND_CHECK: begin
        age = now - tbl_first[0];
        if (tbl_count > 0 && age > cfg_give_up) begin
          results_due.push_back(make_result(RES_KEY_FORCE, tbl_frame[0], tbl_frag[0],
                                            tbl_retry[0], 1'b1));
          tbl_count = 0;
        end else begin
          results_due.push_back(make_result(RES_NO_TMO, 32'd0, 16'd0, 4'd0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  // Prints one mismatch line and counts it.
  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    fail_count++;
  endtask

  // Monitor: configuration, then input, then result transactions per edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      tbl_count   = 0;
      rtt_min     = '0;
      rtt_avg     = '0;
      have_rtt    = 1'b0;
      cfg_retries = 4'd3;
      cfg_weight  = 9'd51;
      cfg_give_up = 32'd1000000;
      results_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_MAX_RETRIES: cfg_retries = cfg_mon.data[3:0];
          CFG_EWMA_WEIGHT: cfg_weight  = cfg_mon.data[8:0];
          CFG_GIVE_UP:     cfg_give_up = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        track_item(in_mon.kind, in_mon.frame_number, in_mon.fragment_number,
                   in_mon.now_us, in_mon.stamp_us);
      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) begin
          report("unexpected result kind", out_mon.result_kind, 0);
        end else begin
          want = results_due.pop_front();
          if (out_mon.result_kind !== want.result_kind)
            report("result_kind", out_mon.result_kind, want.result_kind);
          if (out_mon.out_frame_number !== want.out_frame_number)
            report("out_frame_number", out_mon.out_frame_number, want.out_frame_number);
          if (out_mon.out_fragment_number !== want.out_fragment_number)
            report("out_fragment_number", out_mon.out_fragment_number,
                   want.out_fragment_number);
          if (out_mon.retry_count !== want.retry_count)
            report("retry_count", out_mon.retry_count, want.retry_count);
          if (out_mon.min_rtt_us !== want.min_rtt_us)
            report("min_rtt_us", out_mon.min_rtt_us, want.min_rtt_us);
          if (out_mon.smoothed_rtt_us !== want.smoothed_rtt_us)
            report("smoothed_rtt_us", out_mon.smoothed_rtt_us, want.smoothed_rtt_us);
          if (out_mon.last !== want.last)
            report("last", out_mon.last, want.last);
        end
      end
    end
    pending = results_due.size();
  end

endmodule

/* tb/ack_retransmit_tracker_top_tb.sv */
// ----------------------------------------------------------------------------
// Retransmit tracker testbench
// Drives directed and random send, ack and frame check transactions through
// several register settings, with random stalls on both channels, and leaves
// checking to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker_top_tb;
  import art_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 200;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   quiet;
  bit   in_taken;
  bit   cfg_taken;
  int   stall_left;

  art_in_if  in_ch ();
  art_out_if out_ch ();
  art_cfg_if cfg_ch ();

  ack_retransmit_tracker_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  art_scoreboard u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock and run-length guard.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** ack_retransmit_tracker_top: FAILED **");
      $finish;
    end
  end

  // Handshakes seen at each rising edge, read back at the falling edge.
  always @(posedge clk) begin
    in_taken  <= in_ch.valid && in_ch.ready;
    cfg_taken <= cfg_ch.valid && cfg_ch.ready;
  end

  // Result side back-pressure in short random bursts.
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Offers one input transaction and holds it until it is taken.
  task automatic put_item(logic [1:0] kind, logic [31:0] fr, logic [15:0] fg,
                          logic [31:0] now, logic [31:0] stamp);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(negedge clk);
    in_ch.valid           = 1'b1;
    in_ch.kind            = kind;
    in_ch.frame_number    = fr;
    in_ch.fragment_number = fg;
    in_ch.now_us          = now;
    in_ch.stamp_us        = stamp;
    do @(negedge clk); while (!in_taken);
    in_ch.valid = 1'b0;
  endtask

  task automatic put_cfg(logic [1:0] idx, logic [31:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(negedge clk); while (!cfg_taken);
    cfg_ch.valid = 1'b0;
  endtask

  // Waits until every result due has come, then lets the block go idle.
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_regs(logic [3:0] retries, logic [8:0] weight, logic [31:0] give_up);
    settle();
    put_cfg(CFG_MAX_RETRIES, {28'd0, retries});
    put_cfg(CFG_EWMA_WEIGHT, {23'd0, weight});
    put_cfg(CFG_GIVE_UP, give_up);
  endtask

  // Random traffic: mostly sends and acks of open keys on a running clock.
  task automatic random_phase(int count, logic [31:0] start_us);
    logic [31:0] clock_us;
    logic [31:0] base;
    logic [31:0] fr;
    logic [15:0] fg;
    logic [31:0] stamp;
    logic [47:0] open_keys[$];
    logic [31:0] open_stamps[$];
    int          pick;
    int          sel;
    clock_us = start_us;
    base     = $urandom;
    for (int k = 0; k < count; k++) begin
      clock_us = clock_us + $urandom_range(1, 400);
      pick     = $urandom_range(0, 99);
      if (pick < 45) begin
        fr    = ($urandom_range(0, 3) == 0) ? $urandom : base + $urandom_range(0, 7);
        fg    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        stamp = ($urandom_range(0, 9) == 0) ? $urandom : clock_us;
        put_item(KIND_SEND, fr, fg, clock_us, stamp);
        open_keys.push_back({fr, fg});
        open_stamps.push_back(stamp);
        if (open_keys.size() > 40) begin
          void'(open_keys.pop_front());
          void'(open_stamps.pop_front());
        end
      end else if (pick < 80 && open_keys.size() > 0) begin
        sel = $urandom_range(0, open_keys.size() - 1);
        put_item(KIND_ACK, open_keys[sel][47:16], open_keys[sel][15:0], clock_us,
                 open_stamps[sel]);
        open_keys.delete(sel);
        open_stamps.delete(sel);
      end else if (pick < 88) begin
        put_item(KIND_ACK, $urandom, 16'($urandom), clock_us, $urandom);
      end else if (pick < 95) begin
        put_item(KIND_CHECK, $urandom, 16'($urandom), clock_us, $urandom);
      end else if (pick < 98 && open_keys.size() > 0) begin
        sel = $urandom_range(0, open_keys.size() - 1);
        put_item(KIND_SEND, open_keys[sel][47:16], open_keys[sel][15:0], clock_us, clock_us);
      end else begin
        put_item(KIND_NONE, $urandom, 16'($urandom), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    logic [31:0] fr;
    rst_n           = 1'b0;
    quiet           = 1'b0;
    cycles          = 0;
    stall_left      = 0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_SEND;
    in_ch.frame_number    = '0;
    in_ch.fragment_number = '0;
    in_ch.now_us    = '0;
    in_ch.stamp_us  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_MAX_RETRIES;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b1;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at default-like settings.
    set_regs(4'd3, 9'd51, 32'd1000);
    put_item(KIND_CHECK, 32'd0, 16'd0, 32'd100, 32'd0);
    put_item(KIND_SEND, 32'd0, 16'd0, 32'd100, 32'd100);
    put_item(KIND_SEND, 32'hFFFF_FFFF, 16'hFFFF, 32'd110, 32'd110);
    put_item(KIND_SEND, 32'd5, 16'd1, 32'd120, 32'd120);
    put_item(KIND_SEND, 32'd5, 16'd3, 32'd130, 32'd130);
    put_item(KIND_SEND, 32'd5, 16'd2, 32'd140, 32'd140);
    put_item(KIND_SEND, 32'd5, 16'd2, 32'd150, 32'd150);
    put_item(KIND_ACK, 32'd5, 16'd3, 32'd200, 32'd130);
    put_item(KIND_ACK, 32'd7, 16'd7, 32'd210, 32'd205);
    put_item(KIND_ACK, 32'hFFFF_FFFF, 16'hFFFF, 32'd900, 32'd110);
    put_item(KIND_ACK, 32'd5, 16'd2, 32'd901, 32'hFFFF_FFF0);
    put_item(KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_item(KIND_CHECK, 32'd0, 16'd0, 32'd1100, 32'd0);
    put_item(KIND_CHECK, 32'd0, 16'd0, 32'd1101, 32'd0);
    put_item(KIND_CHECK, 32'd0, 16'd0, 32'd1200, 32'd0);

    // Fill the table past full, ack its largest key, then force a key frame.
    set_regs(4'd15, 9'd0, 32'd5000);
    fr = $urandom;
    for (int k = 0; k < 33; k++)
      put_item(KIND_SEND, fr + k[31:0], k[15:0], 32'd10 + k[31:0], 32'd10 + k[31:0]);
    put_item(KIND_ACK, fr + 32'd31, 16'd31, 32'd400, 32'd300);
    settle();
    put_item(KIND_CHECK, 32'd0, 16'd0, 32'hFFFF_0000, 32'd0);

    // Random part through several register settings.
    set_regs(4'd0, 9'd0, 32'd0);
    random_phase(26, $urandom);
    set_regs(4'd15, 9'd256, 32'hFFFF_FFFF);
    random_phase(26, $urandom);
    set_regs(4'($urandom), 9'd511, 32'($urandom_range(1, 5000)));
    random_phase(26, 32'hFFFF_F000);
    set_regs(4'd1, 9'($urandom), 32'd20000);
    random_phase(26, $urandom);
    set_regs(4'd3, 9'd51, 32'd1000000);
    quiet = 1'b1;
    random_phase(26, $urandom);

    settle();
    if (fail_count == 0) begin
      $display("** ack_retransmit_tracker_top: PASSED **");
    end else begin
      $display("** ack_retransmit_tracker_top: FAILED **");
    end
    $finish;
  end

endmodule
